@@ hdl/atcl_pkg.sv @@
// shared types and constants of the at command line recognizer
`default_nettype none

package atcl_pkg;

  localparam int unsigned PAT_COUNT = 4;
  localparam int unsigned PAT_MAXLEN = 7;
  localparam int unsigned PAT_SLOTS = 8;

  localparam int unsigned PAT_PLUS = 0;
  localparam int unsigned PAT_AT = 1;
  localparam int unsigned PAT_EXIT = 2;
  localparam int unsigned PAT_BOOT = 3;

  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_LF = 8'd10;

  typedef enum logic [2:0] {
    RESP_ENTERED = 3'd0,
    RESP_OK      = 3'd1,
    RESP_BOOT    = 3'd2,
    RESP_EXITED  = 3'd3,
    RESP_ERROR   = 3'd4
  } response_e;

  // pattern text, padded with zeros beyond each pattern
  localparam logic [7:0] PAT_TEXT [PAT_COUNT][PAT_SLOTS] = '{
    '{8'h2B, 8'h2B, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h41, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h41, 8'h54, 8'h2B, 8'h45, 8'h58, 8'h49, 8'h54, 8'h00},
    '{8'h41, 8'h54, 8'h2B, 8'h42, 8'h4F, 8'h4F, 8'h54, 8'h00}
  };

  localparam logic [2:0] PAT_LEN [PAT_COUNT] = '{3'd3, 3'd2, 3'd7, 3'd7};

  typedef struct packed {
    logic                 empty;
    logic [PAT_COUNT-1:0] hit;
  } line_status_t;

endpackage

`default_nettype wire

@@ hdl/atcl_if.sv @@
// stream interfaces for received bytes and responses
`default_nettype none

interface atcl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface atcl_resp_if;
  logic       valid;
  logic       ready;
  logic [2:0] response;
  logic       in_command_mode;

  modport source (output valid, output response, output in_command_mode, input ready);
  modport sink (input valid, input response, input in_command_mode, output ready);
endinterface

`default_nettype wire

@@ hdl/atcl_line_match.sv @@
// line length counter and incremental pattern match flags
`default_nettype none

module atcl_line_match #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire logic [7:0]             byte_i,
  output atcl_pkg::line_status_t      status_o
);
  import atcl_pkg::*;

  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY);

  logic [LEN_W-1:0]     len_q, len_d;
  logic [PAT_COUNT-1:0] flags_q, flags_d;
  logic                 is_term;
  logic                 keep;

  always_comb begin
    is_term = (byte_i == BYTE_CR) || (byte_i == BYTE_LF);
    status_o.empty = (len_q == '0);
    for (int p = 0; p < PAT_COUNT; p++) begin
      status_o.hit[p] = flags_q[p] && (len_q == LEN_W'(PAT_LEN[p]));
    end

    len_d = len_q;
    flags_d = flags_q;
    keep = 1'b0;
    if (step_i && is_term && !status_o.empty) begin
      len_d = '0;
      flags_d = '1;
    end else if (step_i && !is_term && (len_q < LEN_W'(LINE_CAPACITY - 1))) begin
      for (int p = 0; p < PAT_COUNT; p++) begin
        keep = (len_q < LEN_W'(PAT_LEN[p])) && (len_q < LEN_W'(PAT_MAXLEN)) &&
               (PAT_TEXT[p][len_q[2:0]] == byte_i);
        flags_d[p] = flags_q[p] & keep;
      end
      len_d = len_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      flags_q <= '1;
    end else begin
      len_q <= len_d;
      flags_q <= flags_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/at_command_line_recognizer_core.sv @@
// at command line recognizer: byte stream in, mode responses out
//
// in_i carries received bytes; cr or lf ends a line, other bytes are line
// characters, of which up to LINE_CAPACITY-1 per line are kept.
// out_o carries one response per recognized line: entered command mode,
// ok, boot request, exited, or error, plus the mode after the line.
// a byte is registered at its transfer and judged once the output can
// advance, which updates the mode and loads the result register, so a
// response is offered from the result register after its line end.
// one byte per cycle is taken unless a waiting result is stalled; the match
// flags and the line length are the only per-line state, so nothing else holds the input.
// reset returns to idle mode with an empty line and no pending result.
// while the receiver stalls with a result waiting, one more byte is held
// in the input register and in_i.ready drops until the result moves on.
`default_nettype none

module at_command_line_recognizer_core #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  atcl_byte_if.sink   in_i,
  atcl_resp_if.source out_o
);
  import atcl_pkg::*;

  logic         s1_valid_q;
  logic [7:0]   s1_byte_q;
  logic         out_valid_q, out_valid_d;
  response_e    resp_q, resp_d;
  logic         mode_out_q;
  logic         cmd_mode_q, cmd_mode_d;
  logic         advance;
  logic         step;
  logic         is_term;
  logic         res_valid;
  line_status_t status;

  atcl_line_match #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (s1_byte_q),
    .status_o (status)
  );

  assign advance = !out_valid_q || out_o.ready;
  assign step = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  assign out_o.valid = out_valid_q;
  assign out_o.response = resp_q;
  assign out_o.in_command_mode = mode_out_q;

  always_comb begin
    is_term = (s1_byte_q == BYTE_CR) || (s1_byte_q == BYTE_LF);
    res_valid = 1'b0;
    resp_d = RESP_ERROR;
    cmd_mode_d = cmd_mode_q;
    if (step && is_term && !status.empty) begin
      if (!cmd_mode_q) begin
        if (status.hit[PAT_PLUS]) begin
          res_valid = 1'b1;
          resp_d = RESP_ENTERED;
          cmd_mode_d = 1'b1;
        end
      end else begin
        res_valid = 1'b1;
        priority if (status.hit[PAT_AT]) begin
          resp_d = RESP_OK;
        end else if (status.hit[PAT_BOOT]) begin
          resp_d = RESP_BOOT;
          cmd_mode_d = 1'b0;
        end else if (status.hit[PAT_EXIT]) begin
          resp_d = RESP_EXITED;
          cmd_mode_d = 1'b0;
        end else begin
          resp_d = RESP_ERROR;
        end
      end
    end
    out_valid_d = advance ? res_valid : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_mode_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      out_valid_q <= out_valid_d;
      cmd_mode_q <= cmd_mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.byte_in;
    end
    if (res_valid) begin
      resp_q <= resp_d;
      mode_out_q <= cmd_mode_d;
    end
  end

  a_entered_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && resp_q == RESP_ENTERED) |-> mode_out_q)
    else $error("entered response without command mode");

  a_leave_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (resp_q == RESP_BOOT || resp_q == RESP_EXITED)) |-> !mode_out_q)
    else $error("boot or exit response left command mode set");

  a_cmd_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (resp_q == RESP_OK || resp_q == RESP_ERROR)) |-> mode_out_q)
    else $error("ok or error response outside command mode");

  a_mode_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_valid) |=> (out_valid_q && mode_out_q == cmd_mode_q))
    else $error("reported mode differs from mode state");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire
